>>> rtl/core/fbs_pkg.sv
// shared types and constants for the falling body step unit
`default_nettype none

package fbs_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 32;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_GRAVITY       = 3'd0,
      CSR_GRAVITY_DIR_X = 3'd1,
      CSR_GRAVITY_DIR_Y = 3'd2,
      CSR_GRAVITY_DIR_Z = 3'd3,
      CSR_AIR_DENSITY   = 3'd4
   } csr_index_type;

   localparam logic [31:0] GRAVITY_RESET       = 32'd642253;
   localparam logic [15:0] GRAVITY_DIR_X_RESET = 16'h0000;
   localparam logic [15:0] GRAVITY_DIR_Y_RESET = 16'hC000;
   localparam logic [15:0] GRAVITY_DIR_Z_RESET = 16'h0000;
   localparam logic [31:0] AIR_DENSITY_RESET   = 32'd80282;

   // clock edges from an accepted transaction to its result strobe
   localparam int unsigned PIPE_LATENCY = 9;

   typedef struct packed {
      logic force_accel;
      logic force_limit;
   } fbs_flags_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } fbs_pos_type;

   function automatic logic signed [31:0] sat32(input logic signed [34:0] value);
      logic signed [31:0] result;
      if (value > 35'sd2147483647) begin
         result = 32'sh7FFF_FFFF;
      end else if (value < -35'sd2147483648) begin
         result = 32'sh8000_0000;
      end else begin
         result = value[31:0];
      end
      return result;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/fbs_terminal_check.sv
// six stage pipelined terminal speed test: v^2 * rho * area * cd <= 2 * mass * g
`default_nettype none

module fbs_terminal_check (
   input  wire logic                  clock,
   input  wire logic [31:0]           speed,
   input  wire logic [31:0]           mass,
   input  wire logic [31:0]           area,
   input  wire logic [31:0]           drag_coeff,
   input  wire logic [31:0]           air_density,
   input  wire logic [31:0]           gravity,
   input  wire fbs_pkg::fbs_flags_type flags,
   output logic                       accel
);

   // stage 1
   logic [61:0]            vv_s1_ff;
   logic [63:0]            ra_s1_ff;
   logic [62:0]            mg_s1_ff;
   logic [31:0]            cd_s1_ff;
   // stage 2
   logic [61:0]            vv_s2_ff;
   logic [63:0]            rc_lo_s2_ff;
   logic [63:0]            rc_hi_s2_ff;
   logic [62:0]            mg_s2_ff;
   // stage 3
   logic [61:0]            vv_s3_ff;
   logic [95:0]            rac_s3_ff;
   logic [62:0]            mg_s3_ff;
   // stage 4
   logic [63:0]            pp0_ff [0:2];
   logic [61:0]            pp1_ff [0:2];
   logic [62:0]            mg_s4_ff;
   // stage 5
   logic [127:0]           q0_s5_ff;
   logic [125:0]           q1_s5_ff;
   logic [62:0]            mg_s5_ff;
   // stage 6
   logic [159:0]           lhs_s6_ff;
   logic [62:0]            mg_s6_ff;

   fbs_pkg::fbs_flags_type flags_ff [0:5];

   logic [63:0]            pp0_in [0:2];
   logic [61:0]            pp1_in [0:2];
   logic [127:0]           q0_in;
   logic [125:0]           q1_in;
   logic [159:0]           lhs_in;
   logic [159:0]           rhs;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         pp0_in[j] = 64'(vv_s3_ff[31:0]) * 64'(rac_s3_ff[32*j +: 32]);
         pp1_in[j] = 62'(vv_s3_ff[61:32]) * 62'(rac_s3_ff[32*j +: 32]);
      end
   end

   assign q0_in  = {64'd0, pp0_ff[0]} + {32'd0, pp0_ff[1], 32'd0} + {pp0_ff[2], 64'd0};
   assign q1_in  = {64'd0, pp1_ff[0]} + {32'd0, pp1_ff[1], 32'd0} + {pp1_ff[2], 64'd0};
   assign lhs_in = {32'd0, q0_s5_ff} + {2'd0, q1_s5_ff, 32'd0};
   assign rhs    = {48'd0, mg_s6_ff, 49'd0};

   always_ff @(posedge clock) begin
      vv_s1_ff    <= 62'(speed[30:0]) * 62'(speed[30:0]);
      ra_s1_ff    <= 64'(air_density) * 64'(area);
      mg_s1_ff    <= 63'(mass) * 63'(gravity[30:0]);
      cd_s1_ff    <= drag_coeff;

      vv_s2_ff    <= vv_s1_ff;
      rc_lo_s2_ff <= 64'(ra_s1_ff[31:0]) * 64'(cd_s1_ff);
      rc_hi_s2_ff <= 64'(ra_s1_ff[63:32]) * 64'(cd_s1_ff);
      mg_s2_ff    <= mg_s1_ff;

      vv_s3_ff    <= vv_s2_ff;
      rac_s3_ff   <= {32'd0, rc_lo_s2_ff} + {rc_hi_s2_ff, 32'd0};
      mg_s3_ff    <= mg_s2_ff;

      pp0_ff      <= pp0_in;
      pp1_ff      <= pp1_in;
      mg_s4_ff    <= mg_s3_ff;

      q0_s5_ff    <= q0_in;
      q1_s5_ff    <= q1_in;
      mg_s5_ff    <= mg_s4_ff;

      lhs_s6_ff   <= lhs_in;
      mg_s6_ff    <= mg_s5_ff;

      flags_ff[0] <= flags;
      for (int i = 1; i < 6; i++) begin
         flags_ff[i] <= flags_ff[i-1];
      end
   end

   assign accel = flags_ff[5].force_accel
                  | (!flags_ff[5].force_limit && (lhs_s6_ff <= rhs));

endmodule

`default_nettype wire

>>> rtl/core/falling_body_step_unit.sv
// top level of the falling body step unit
`default_nettype none

// Advances one body per transaction by one frame under gravity, holding
// acceleration back once the body is past terminal speed. A new transaction
// is taken on every clock (busy stays low) and its result appears on the rsp_
// ports with rsp_valid high for one cycle; transactions with req_slot_used
// low give no result. The receiver cannot hold results off, so each result
// must be taken in the cycle it is shown. The latency is set by the terminal
// speed test, three levels of multiplication split into 32x32 partial
// products and summed over six stages, followed by the position scaling by
// the gravity direction and the final saturating add. Configuration writes
// land on the next edge and must be issued only while no transaction is in
// flight.
module falling_body_step_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_slot_used,
   input  wire logic [31:0]        req_mass,
   input  wire logic [31:0]        req_area,
   input  wire logic [31:0]        req_drag_coeff,
   input  wire logic signed [31:0] req_speed,
   input  wire logic signed [31:0] req_pos_x,
   input  wire logic signed [31:0] req_pos_y,
   input  wire logic signed [31:0] req_pos_z,
   input  wire logic [15:0]        req_time_step,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_new_speed,
   output logic signed [31:0]      rsp_new_pos_x,
   output logic signed [31:0]      rsp_new_pos_y,
   output logic signed [31:0]      rsp_new_pos_z,
   output logic                    rsp_limited,
   input  wire logic               csr_write_en,
   input  wire logic [fbs_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [fbs_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   // configuration
   logic signed [31:0]     gravity_ff;
   logic signed [15:0]     dir_x_ff;
   logic signed [15:0]     dir_y_ff;
   logic signed [15:0]     dir_z_ff;
   logic [31:0]            air_density_ff;

   // pipeline
   logic                   valid_ff [0:fbs_pkg::PIPE_LATENCY-1];
   fbs_pkg::fbs_pos_type   pos_ff [0:7];
   logic signed [31:0]     v_ff [0:5];
   logic signed [47:0]     gd_ff [0:5];
   logic signed [47:0]     vd_ff [0:5];
   logic [15:0]            dt_s1_ff;
   logic signed [63:0]     gdd_s2_ff;
   logic signed [48:0]     d_acc_ff [0:3];
   logic signed [48:0]     d_s7_ff;
   logic signed [31:0]     speed_ff [0:1];
   logic                   limited_ff [0:1];
   logic signed [63:0]     prod_x_s8_ff;
   logic signed [63:0]     prod_y_s8_ff;
   logic signed [63:0]     prod_z_s8_ff;

   logic                   accept;
   fbs_pkg::fbs_flags_type flags;
   logic                   accel;
   logic signed [47:0]     vd_in;
   logic signed [47:0]     gd_in;
   logic signed [63:0]     gdd_in;
   logic signed [46:0]     gdd_half;
   logic signed [48:0]     d_acc_in;
   logic signed [31:0]     gd_step;
   logic signed [34:0]     speed_sum;
   logic signed [31:0]     speed_in;
   logic signed [48:0]     d_in;
   logic signed [63:0]     prod_x_in;
   logic signed [63:0]     prod_y_in;
   logic signed [63:0]     prod_z_in;
   logic signed [34:0]     pos_x_sum;
   logic signed [34:0]     pos_y_sum;
   logic signed [34:0]     pos_z_sum;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff     <= fbs_pkg::GRAVITY_RESET;
         dir_x_ff       <= fbs_pkg::GRAVITY_DIR_X_RESET;
         dir_y_ff       <= fbs_pkg::GRAVITY_DIR_Y_RESET;
         dir_z_ff       <= fbs_pkg::GRAVITY_DIR_Z_RESET;
         air_density_ff <= fbs_pkg::AIR_DENSITY_RESET;
      end else if (csr_write_en) begin
         unique case (fbs_pkg::csr_index_type'(csr_index))
            fbs_pkg::CSR_GRAVITY:       gravity_ff     <= csr_wdata;
            fbs_pkg::CSR_GRAVITY_DIR_X: dir_x_ff       <= csr_wdata[15:0];
            fbs_pkg::CSR_GRAVITY_DIR_Y: dir_y_ff       <= csr_wdata[15:0];
            fbs_pkg::CSR_GRAVITY_DIR_Z: dir_z_ff       <= csr_wdata[15:0];
            fbs_pkg::CSR_AIR_DENSITY:   air_density_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign flags.force_accel = req_speed[31] || (air_density_ff == 32'd0)
                              || (req_area == 32'd0) || (req_drag_coeff == 32'd0);
   assign flags.force_limit = gravity_ff[31];

   fbs_terminal_check u_check (
      .clock       (clock),
      .speed       (req_speed),
      .mass        (req_mass),
      .area        (req_area),
      .drag_coeff  (req_drag_coeff),
      .air_density (air_density_ff),
      .gravity     (gravity_ff),
      .flags       (flags),
      .accel       (accel)
   );

   // stage 1
   assign vd_in = 48'(req_speed) * 48'($signed({1'b0, req_time_step}));
   assign gd_in = 48'(gravity_ff) * 48'($signed({1'b0, req_time_step}));
   // stage 2
   assign gdd_in = 64'(gd_ff[0]) * 64'($signed({1'b0, dt_s1_ff}));
   // stage 3
   assign gdd_half = 47'(gdd_s2_ff >>> 17);
   assign d_acc_in = 49'(vd_ff[1]) + 49'(gdd_half);
   // stage 7
   assign gd_step   = 32'(gd_ff[5] >>> 16);
   assign speed_sum = 35'(v_ff[5]) + 35'(gd_step);
   assign speed_in  = accel ? fbs_pkg::sat32(speed_sum) : v_ff[5];
   assign d_in      = accel ? d_acc_ff[3] : 49'(vd_ff[5]);
   // stage 8
   assign prod_x_in = 64'(dir_x_ff) * 64'(d_s7_ff);
   assign prod_y_in = 64'(dir_y_ff) * 64'(d_s7_ff);
   assign prod_z_in = 64'(dir_z_ff) * 64'(d_s7_ff);
   // stage 9
   assign pos_x_sum = 35'(pos_ff[7].x) + 35'(prod_x_s8_ff >>> 30);
   assign pos_y_sum = 35'(pos_ff[7].y) + 35'(prod_y_s8_ff >>> 30);
   assign pos_z_sum = 35'(pos_ff[7].z) + 35'(prod_z_s8_ff >>> 30);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fbs_pkg::PIPE_LATENCY; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= accept && req_slot_used;
         for (int i = 1; i < fbs_pkg::PIPE_LATENCY; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff[0].x <= req_pos_x;
      pos_ff[0].y <= req_pos_y;
      pos_ff[0].z <= req_pos_z;
      for (int i = 1; i < 8; i++) begin
         pos_ff[i] <= pos_ff[i-1];
      end

      v_ff[0]  <= req_speed;
      gd_ff[0] <= gd_in;
      vd_ff[0] <= vd_in;
      for (int i = 1; i < 6; i++) begin
         v_ff[i]  <= v_ff[i-1];
         gd_ff[i] <= gd_ff[i-1];
         vd_ff[i] <= vd_ff[i-1];
      end
      dt_s1_ff  <= req_time_step;
      gdd_s2_ff <= gdd_in;

      d_acc_ff[0] <= d_acc_in;
      for (int i = 1; i < 4; i++) begin
         d_acc_ff[i] <= d_acc_ff[i-1];
      end

      d_s7_ff       <= d_in;
      speed_ff[0]   <= speed_in;
      speed_ff[1]   <= speed_ff[0];
      limited_ff[0] <= !accel;
      limited_ff[1] <= limited_ff[0];

      prod_x_s8_ff <= prod_x_in;
      prod_y_s8_ff <= prod_y_in;
      prod_z_s8_ff <= prod_z_in;

      rsp_new_speed <= speed_ff[1];
      rsp_limited   <= limited_ff[1];
      rsp_new_pos_x <= fbs_pkg::sat32(pos_x_sum);
      rsp_new_pos_y <= fbs_pkg::sat32(pos_y_sum);
      rsp_new_pos_z <= fbs_pkg::sat32(pos_z_sum);
   end

   assign rsp_valid = valid_ff[fbs_pkg::PIPE_LATENCY-1];

`ifndef NO_ASSERTIONS
   // every used-slot transaction gets its result after the fixed latency
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (accept && req_slot_used) |-> ##(fbs_pkg::PIPE_LATENCY) rsp_valid)
      else $error("result missing after accepted transaction");

   // a result only appears for a used-slot transaction taken earlier
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept && req_slot_used, fbs_pkg::PIPE_LATENCY))
      else $error("result without matching transaction");

   // withheld acceleration leaves the speed unchanged
   a_limited_speed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_limited)
      |-> (rsp_new_speed == $past(req_speed, fbs_pkg::PIPE_LATENCY)))
      else $error("speed changed on limited step");
`endif

endmodule

`default_nettype wire

>>> tb/sv/fbs_checker.sv
`timescale 1ns / 1ps
// checker that predicts falling body step results and compares them with the unit's output
module fbs_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               busy,
   input  wire logic               req_slot_used,
   input  wire logic [31:0]        req_mass,
   input  wire logic [31:0]        req_area,
   input  wire logic [31:0]        req_drag_coeff,
   input  wire logic signed [31:0] req_speed,
   input  wire logic signed [31:0] req_pos_x,
   input  wire logic signed [31:0] req_pos_y,
   input  wire logic signed [31:0] req_pos_z,
   input  wire logic [15:0]        req_time_step,
   input  wire logic               rsp_valid,
   input  wire logic signed [31:0] rsp_new_speed,
   input  wire logic signed [31:0] rsp_new_pos_x,
   input  wire logic signed [31:0] rsp_new_pos_y,
   input  wire logic signed [31:0] rsp_new_pos_z,
   input  wire logic               rsp_limited,
   input  wire logic               csr_write_en,
   input  wire logic [fbs_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [fbs_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output int unsigned             fail_count,
   output int unsigned             pending
);

   typedef struct packed {
      logic signed [31:0] speed;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic               limited;
   } body_step_type;

   logic signed [31:0] gravity;
   logic signed [15:0] dir_x;
   logic signed [15:0] dir_y;
   logic signed [15:0] dir_z;
   logic [31:0]        air_density;

   body_step_type expected_steps[$];

   function automatic logic signed [31:0] clamp32(input logic signed [95:0] x);
      if (x > 96'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (x < -96'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return x[31:0];
   endfunction

   function automatic body_step_type advance_body(
      input logic [31:0]        mass,
      input logic [31:0]        area,
      input logic [31:0]        drag,
      input logic signed [31:0] speed,
      input logic signed [31:0] px,
      input logic signed [31:0] py,
      input logic signed [31:0] pz,
      input logic [15:0]        dt
   );
      body_step_type      r;
      logic [191:0]       speed_u;
      logic [191:0]       drag_term;
      logic [191:0]       weight_term;
      logic signed [95:0] v, g, t, acc, acc_dt, step_dist;
      logic signed [95:0] pxw, pyw, pzw, dxw, dyw, dzw;
      logic               accel;
      v   = speed;
      g   = gravity;
      t   = dt;
      pxw = px;
      pyw = py;
      pzw = pz;
      dxw = dir_x;
      dyw = dir_y;
      dzw = dir_z;
      if (speed < 0 || air_density == 0 || area == 0 || drag == 0) begin
         accel = 1'b1;
      end else if (gravity < 0) begin
         accel = 1'b0;
      end else begin
         speed_u     = {160'd0, speed};
         drag_term   = speed_u * speed_u * {160'd0, air_density} * {160'd0, area} *
                       {160'd0, drag};
         weight_term = ({160'd0, mass} * {160'd0, gravity}) << 49;
         accel       = (drag_term <= weight_term);
      end
      acc       = accel ? g : '0;
      acc_dt    = acc * t;
      step_dist = v * t + ((acc_dt * t) >>> 17);
      r.speed   = clamp32(v + (acc_dt >>> 16));
      r.pos_x   = clamp32(pxw + ((dxw * step_dist) >>> 30));
      r.pos_y   = clamp32(pyw + ((dyw * step_dist) >>> 30));
      r.pos_z   = clamp32(pzw + ((dzw * step_dist) >>> 30));
      r.limited = !accel;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %08h expected %08h at %0t", what, got, want, $time);
      fail_count++;
   endtask

   always @(posedge clock) begin
      body_step_type want;
      if (reset) begin
         gravity     <= fbs_pkg::GRAVITY_RESET;
         dir_x       <= fbs_pkg::GRAVITY_DIR_X_RESET;
         dir_y       <= fbs_pkg::GRAVITY_DIR_Y_RESET;
         dir_z       <= fbs_pkg::GRAVITY_DIR_Z_RESET;
         air_density <= fbs_pkg::AIR_DENSITY_RESET;
         expected_steps.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_steps.size() == 0) begin
               report_mismatch("result with no transaction pending", rsp_new_speed, '0);
            end else begin
               want = expected_steps.pop_front();
               if (rsp_new_speed !== want.speed) begin
                  report_mismatch("new_speed", rsp_new_speed, want.speed);
               end
               if (rsp_new_pos_x !== want.pos_x) begin
                  report_mismatch("new_pos_x", rsp_new_pos_x, want.pos_x);
               end
               if (rsp_new_pos_y !== want.pos_y) begin
                  report_mismatch("new_pos_y", rsp_new_pos_y, want.pos_y);
               end
               if (rsp_new_pos_z !== want.pos_z) begin
                  report_mismatch("new_pos_z", rsp_new_pos_z, want.pos_z);
               end
               if (rsp_limited !== want.limited) begin
                  report_mismatch("limited", {31'd0, rsp_limited}, {31'd0, want.limited});
               end
            end
         end
         if (start && !busy && req_slot_used) begin
            expected_steps.insert(expected_steps.size(),
                                  advance_body(req_mass, req_area, req_drag_coeff,
                                               req_speed, req_pos_x, req_pos_y,
                                               req_pos_z, req_time_step));
         end
         if (csr_write_en) begin
            case (csr_index)
               fbs_pkg::CSR_GRAVITY: begin
                  gravity <= csr_wdata;
               end
               fbs_pkg::CSR_GRAVITY_DIR_X: begin
                  dir_x <= csr_wdata[15:0];
               end
               fbs_pkg::CSR_GRAVITY_DIR_Y: begin
                  dir_y <= csr_wdata[15:0];
               end
               fbs_pkg::CSR_GRAVITY_DIR_Z: begin
                  dir_z <= csr_wdata[15:0];
               end
               fbs_pkg::CSR_AIR_DENSITY: begin
                  air_density <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
      end
      pending = expected_steps.size();
   end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// testbench top for the falling body step unit: clock, reset, stimulus and verdict
module tb_top;

   localparam int unsigned STALL_LIMIT   = 1000;
   localparam int unsigned PHASE_BODIES  = 116;
   localparam int unsigned RANDOM_PHASES = 8;
   localparam logic [15:0] FRAME_60HZ    = 16'd1092;
   localparam logic [31:0] ONE_Q16       = 32'h0001_0000;

   typedef struct {
      logic               used;
      logic [31:0]        mass;
      logic [31:0]        area;
      logic [31:0]        drag;
      logic signed [31:0] speed;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
      logic [15:0]        dt;
   } body_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic               req_slot_used  = 1'b0;
   logic [31:0]        req_mass       = '0;
   logic [31:0]        req_area       = '0;
   logic [31:0]        req_drag_coeff = '0;
   logic signed [31:0] req_speed      = '0;
   logic signed [31:0] req_pos_x      = '0;
   logic signed [31:0] req_pos_y      = '0;
   logic signed [31:0] req_pos_z      = '0;
   logic [15:0]        req_time_step  = '0;
   logic               rsp_valid;
   logic signed [31:0] rsp_new_speed;
   logic signed [31:0] rsp_new_pos_x;
   logic signed [31:0] rsp_new_pos_y;
   logic signed [31:0] rsp_new_pos_z;
   logic               rsp_limited;
   logic                                csr_write_en = 1'b0;
   logic [fbs_pkg::CSR_INDEX_WIDTH-1:0] csr_index    = '0;
   logic [fbs_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata    = '0;
   int unsigned fail_count;
   int unsigned pending;
   int unsigned stall_cycles = 0;
   bit          gaps_on = 1'b1;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   falling_body_step_unit dut (.*);

   fbs_checker u_checker (.*);

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || csr_write_en) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic body_type make_body(
      input logic used, input logic [31:0] mass, input logic [31:0] area,
      input logic [31:0] drag, input logic [31:0] speed, input logic [31:0] px,
      input logic [31:0] py, input logic [31:0] pz, input logic [15:0] dt
   );
      body_type b;
      b.used  = used;
      b.mass  = mass;
      b.area  = area;
      b.drag  = drag;
      b.speed = speed;
      b.px    = px;
      b.py    = py;
      b.pz    = pz;
      b.dt    = dt;
      return b;
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         4, 5: return $urandom_range(0, 1 << 20);
         default: return $urandom();
      endcase
   endfunction

   function automatic body_type random_body();
      body_type b;
      int       style;
      style = $urandom_range(0, 99);
      if (style < 30) begin
         b = make_body(1'($urandom_range(0, 1)), pick_word(), pick_word(), pick_word(),
                       pick_word(), pick_word(), pick_word(), pick_word(),
                       16'(pick_word()));
      end else begin
         // plausible body near its terminal speed
         b.used  = (style >= 40);
         b.mass  = $urandom_range(1 << 14, 200 << 16);
         b.area  = $urandom_range(1 << 12, 4 << 16);
         b.drag  = $urandom_range(1 << 14, 2 << 16);
         b.speed = $urandom_range(0, 180 << 16) - (20 << 16);
         b.px    = $urandom_range(0, 2000 << 16) - (1000 << 16);
         b.py    = $urandom_range(0, 2000 << 16) - (1000 << 16);
         b.pz    = $urandom_range(0, 2000 << 16) - (1000 << 16);
         b.dt    = $urandom_range(0, 1) ? FRAME_60HZ : 16'($urandom_range(0, 65535));
      end
      return b;
   endfunction

   function automatic logic [31:0] pick_gravity();
      case ($urandom_range(0, 7))
         0, 1: return fbs_pkg::GRAVITY_RESET;
         2: return $urandom_range(1 << 14, 30 << 16);
         3: return -$urandom_range(1 << 14, 30 << 16);
         4: return $urandom();
         5: return '0;
         default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      endcase
   endfunction

   function automatic logic [15:0] pick_dir();
      case ($urandom_range(0, 4))
         0: return '0;
         1, 2: return $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
         3: return 16'($urandom());
         default: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      endcase
   endfunction

   function automatic logic [31:0] pick_density();
      case ($urandom_range(0, 5))
         0, 1: return fbs_pkg::AIR_DENSITY_RESET;
         2: return $urandom_range(1 << 12, 4 << 16);
         3: return '0;
         default: return $urandom();
      endcase
   endfunction

   task automatic send_body(input body_type b);
      while (gaps_on && $urandom_range(0, 99) < 28) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start          <= 1'b1;
      req_slot_used  <= b.used;
      req_mass       <= b.mass;
      req_area       <= b.area;
      req_drag_coeff <= b.drag;
      req_speed      <= b.speed;
      req_pos_x      <= b.px;
      req_pos_y      <= b.py;
      req_pos_z      <= b.pz;
      req_time_step  <= b.dt;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
   endtask

   // waits out every pending result and the tail of the pipeline
   task automatic drain_pipe();
      @(negedge clock);
      start <= 1'b0;
      while (pending != 0) begin
         @(negedge clock);
      end
      repeat (fbs_pkg::PIPE_LATENCY + 2) @(negedge clock);
   endtask

   task automatic write_reg(input logic [fbs_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [31:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic set_config(input logic [31:0] g, input logic [15:0] dx,
                             input logic [15:0] dy, input logic [15:0] dz,
                             input logic [31:0] rho);
      drain_pipe();
      write_reg(fbs_pkg::CSR_GRAVITY, g);
      write_reg(fbs_pkg::CSR_GRAVITY_DIR_X, {16'($urandom()), dx});
      write_reg(fbs_pkg::CSR_GRAVITY_DIR_Y, {16'($urandom()), dy});
      write_reg(fbs_pkg::CSR_GRAVITY_DIR_Z, {16'($urandom()), dz});
      write_reg(fbs_pkg::CSR_AIR_DENSITY, rho);
      for (int k = fbs_pkg::CSR_AIR_DENSITY + 1; k < (1 << fbs_pkg::CSR_INDEX_WIDTH);
           k++) begin
         write_reg(k[fbs_pkg::CSR_INDEX_WIDTH-1:0], $urandom());
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset configuration: gravity straight down y
      send_body(make_body(1'b0, '1, '1, '1, '1, '1, '1, '1, '1));
      send_body(make_body(1'b1, 70 << 16, 32'h0000_B333, ONE_Q16, 5 << 16, 0, 100 << 16,
                          0, FRAME_60HZ));
      send_body(make_body(1'b1, 70 << 16, 32'h0000_B333, ONE_Q16, 100 << 16, 0, 100 << 16,
                          0, FRAME_60HZ));
      send_body(make_body(1'b1, '1, '1, '1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, '1));
      send_body(make_body(1'b1, '0, '0, '0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, '1));
      send_body(make_body(1'b1, '1, '0, '1, 32'h7FFF_FFFF, 0, 0, 0, '1));
      send_body(make_body(1'b1, '1, '1, '0, 32'h7FFF_FFFF, 0, 0, 0, '1));
      send_body(make_body(1'b1, '0, '1, '1, 0, 0, 0, 0, '1));
      send_body(make_body(1'b1, 10 << 16, ONE_Q16, ONE_Q16, 50 << 16, 7, 7, 7, '0));
      send_body(make_body(1'b1, '0, ONE_Q16, ONE_Q16, 1, 0, 0, 0, FRAME_60HZ));

      // terminal speed exactly at the boundary
      set_config(ONE_Q16, 16'h4000, 16'h4000, 16'h4000, ONE_Q16);
      send_body(make_body(1'b1, 1 << 15, ONE_Q16, ONE_Q16, ONE_Q16, 0, 0, 0, '1));
      send_body(make_body(1'b1, (1 << 15) - 1, ONE_Q16, ONE_Q16, ONE_Q16, 0, 0, 0, '1));
      send_body(make_body(1'b1, 1 << 15, ONE_Q16, ONE_Q16, ONE_Q16 + 1, 0, 0, 0, '1));

      // most negative gravity, extreme directions, densest air
      set_config(32'h8000_0000, 16'h8000, 16'h8000, 16'h7FFF, '1);
      send_body(make_body(1'b1, ONE_Q16, ONE_Q16, ONE_Q16, 0, 0, 0, 0, FRAME_60HZ));
      send_body(make_body(1'b1, ONE_Q16, ONE_Q16, ONE_Q16, '1, 32'h7FFF_FFFF,
                          32'h8000_0000, 32'h7FFF_FFFF, '1));
      send_body(make_body(1'b1, '1, '1, '1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'h8000_0000, '1));
      send_body(make_body(1'b1, '1, 1, 1, 1, 0, 0, 0, '1));

      // strongest gravity with no air at all
      set_config(32'h7FFF_FFFF, 16'h7FFF, 16'h8000, 16'h0000, '0);
      send_body(make_body(1'b1, '1, '1, '1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, '1));
      send_body(make_body(1'b1, 0, '1, '1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, '1));
      send_body(random_body());

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         set_config(pick_gravity(), pick_dir(), pick_dir(), pick_dir(), pick_density());
         gaps_on = (p != 3);
         for (int n = 0; n < PHASE_BODIES; n++) begin
            send_body(random_body());
         end
      end

      drain_pipe();
      if (fail_count == 0 && pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
